/* rtl/mbrtu_pkg.sv */
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Types, codes and the CRC16 byte step shared by the read master's modules.
// ----------------------------------------------------------------------------
package mbrtu_pkg;

    // operation codes of an input request
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_RX_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_ATTEMPTS  = 2'd1;
    localparam logic [1:0] CFG_START_REG = 2'd2;

    // configuration reset values
    localparam logic [15:0] TIMEOUT_RST   = 16'd1000;
    localparam logic [1:0]  ATTEMPTS_RST  = 2'd3;
    localparam logic [15:0] START_REG_RST = 16'd0;

    // result kinds and completion status
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;
    localparam logic ST_OK     = 1'b0;
    localparam logic ST_FAIL   = 1'b1;

    // frame constants
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [7:0]  FUNC_READ = 8'h03;
    localparam logic [7:0]  COUNT_HI  = 8'h00;
    localparam logic [7:0]  COUNT_LO  = 8'h01;

    // receive phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HUNT,
        PH_COLLECT
    } t_phase;

    // input request payload
    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] slave_address;
        logic [7:0] rx_byte;
    } t_req;

    // result payload
    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic        status;
        logic [15:0] reading;
    } t_res;

    // job handed to the transmit sequencer
    typedef struct packed {
        logic        frame;
        logic [7:0]  addr;
        logic [15:0] start_reg;
        logic        status;
        logic [15:0] reading;
    } t_tx_job;

    // one byte of the reflected CRC16, bit at a time
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* rtl/mbrtu_tx.sv */
// ----------------------------------------------------------------------------
// mbrtu_tx
// Result slot: emits an 8-byte read frame one byte per beat, building the
// CRC as bytes leave, or a single completion result.
// ----------------------------------------------------------------------------
module mbrtu_tx
    import mbrtu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_tx_job i_job,
    output logic    o_ready,
    output logic    o_valid,
    input  logic    i_stall,
    output t_res    o_res
);

    logic        r_valid;
    t_res        r_res;
    logic [2:0]  r_beat;
    logic [15:0] r_crc;
    logic [15:0] r_sreg;

    logic        take;
    logic [2:0]  beat_nx;
    logic [15:0] crc_nx;
    logic [7:0]  byte_nx;

    assign take    = r_valid && !i_stall;
    assign o_ready = !r_valid || (take && r_res.last);
    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign beat_nx = r_beat + 3'd1;
    assign crc_nx  = crc_byte(r_crc, r_res.tx_byte);

    // pick the next frame byte
    always_comb begin
        unique case (beat_nx)
            3'd1:    byte_nx = FUNC_READ;
            3'd2:    byte_nx = r_sreg[15:8];
            3'd3:    byte_nx = r_sreg[7:0];
            3'd4:    byte_nx = COUNT_HI;
            3'd5:    byte_nx = COUNT_LO;
            3'd6:    byte_nx = crc_nx[7:0];
            3'd7:    byte_nx = r_crc[15:8];
            default: byte_nx = 8'h00;
        endcase
    end

    // hold the slot valid until the last beat is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (take && r_res.last) begin
            r_valid <= 1'b0;
        end
    end

    // load a job or advance through the frame
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_beat <= 3'd0;
            r_crc  <= CRC_INIT;
            r_sreg <= i_job.start_reg;
            if (i_job.frame) begin
                r_res <= '{kind: KIND_TX, tx_byte: i_job.addr, last: 1'b0,
                           status: ST_OK, reading: 16'h0000};
            end else begin
                r_res <= '{kind: KIND_DONE, tx_byte: 8'h00, last: 1'b1,
                           status: i_job.status, reading: i_job.reading};
            end
        end else if (take && !r_res.last) begin
            r_beat         <= beat_nx;
            r_res.tx_byte  <= byte_nx;
            r_res.last     <= (beat_nx == 3'd7);
            if (r_beat < 3'd6) begin
                r_crc <= crc_nx;
            end
        end
    end

endmodule

/* rtl/modbus_rtu_register_read_master_core.sv */
// ----------------------------------------------------------------------------
// modbus_rtu_register_read_master_core
// Modbus RTU master that reads one holding register over a byte stream.
// ----------------------------------------------------------------------------
// A request enters a one-entry input register and is decoded in the next
// cycle, so requests that cause no result (bytes, ticks) flow at one per
// cycle. A start, or a tick that retries, yields an 8-byte frame that leaves
// at one byte per cycle while the output is not stalled, from a single
// result slot; a timeout failure or a good reply yields one completion
// result. A request that causes results waits in the input register while
// the slot still holds an earlier result, and the next result-causing
// request enters the slot in the cycle that result's last beat is taken.
// The reply CRC is updated one received byte per request; the frame CRC is
// built byte by byte as the frame leaves.
// ----------------------------------------------------------------------------
module modbus_rtu_register_read_master_core
    import mbrtu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // request channel
    input  logic        i_valid,
    output logic        o_stall,
    input  t_req        i_req,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output t_res        o_res
);

    // configuration
    logic [15:0] r_timeout;
    logic [1:0]  r_max_att;
    logic [15:0] r_start_reg;

    // input register
    logic        r_in_valid;
    t_req        r_in;

    // protocol state
    t_phase      r_phase, n_phase;
    logic [7:0]  r_target, n_target;
    logic [1:0]  r_attempts, n_attempts;
    logic [15:0] r_ticks, n_ticks;
    logic [2:0]  r_idx, n_idx;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_rep3, n_rep3;
    logic [7:0]  r_rep4, n_rep4;
    logic [7:0]  r_rep5, n_rep5;

    logic        has_result;
    t_tx_job     job;
    logic        tx_ready;
    logic        advance;
    logic        in_take;

    logic [15:0] limit;
    logic [1:0]  tries;
    logic [15:0] tick_nx;
    logic [15:0] crc_rx;
    logic        is_start, is_byte, is_tick;
    logic        hit_addr, frame_end, crc_ok, expire, retry;

    assign advance = r_in_valid && (!has_result || tx_ready);
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    // take configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TIMEOUT_RST;
            r_max_att   <= ATTEMPTS_RST;
            r_start_reg <= START_REG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data;
                CFG_ATTEMPTS:  r_max_att   <= i_cfg_data[1:0];
                CFG_START_REG: r_start_reg <= i_cfg_data;
                default:       ;
            endcase
        end
    end

    // hold a request until decode advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_req;
        end
    end

    // decode conditions
    assign limit     = (r_timeout == 16'd0) ? 16'd1 : r_timeout;
    assign tries     = (r_max_att == 2'd0) ? 2'd1 : r_max_att;
    assign tick_nx   = (r_ticks == 16'hFFFF) ? r_ticks : r_ticks + 16'd1;
    assign crc_rx    = crc_byte((r_phase == PH_HUNT) ? CRC_INIT : r_crc, r_in.rx_byte);
    assign is_start  = (r_in.operation == OP_START);
    assign is_byte   = (r_in.operation == OP_RX_BYTE);
    assign is_tick   = (r_in.operation == OP_TICK);
    assign hit_addr  = is_byte && (r_phase == PH_HUNT) && (r_in.rx_byte == r_target);
    assign frame_end = is_byte && (r_phase == PH_COLLECT) && (r_idx >= 3'd6);
    assign crc_ok    = (r_crc[7:0] == r_rep5) && (r_crc[15:8] == r_in.rx_byte);
    assign expire    = is_tick && (r_phase != PH_IDLE) && (tick_nx >= limit);
    assign retry     = expire && (r_attempts < tries);

    // next receive phase
    always_comb begin
        n_phase = r_phase;
        if (is_start || retry) begin
            n_phase = PH_HUNT;
        end else if (hit_addr) begin
            n_phase = PH_COLLECT;
        end else if (frame_end) begin
            n_phase = crc_ok ? PH_IDLE : PH_HUNT;
        end else if (expire) begin
            n_phase = PH_IDLE;
        end
    end

    // next datapath state and result job
    always_comb begin
        n_target   = r_target;
        n_attempts = r_attempts;
        n_ticks    = r_ticks;
        n_idx      = r_idx;
        n_crc      = r_crc;
        n_rep3     = r_rep3;
        n_rep4     = r_rep4;
        n_rep5     = r_rep5;
        has_result = 1'b0;
        job        = '{frame: 1'b1, addr: r_target, start_reg: r_start_reg,
                       status: ST_OK, reading: 16'h0000};
        case (r_in.operation)
            OP_START: begin
                n_target   = r_in.slave_address;
                n_attempts = 2'd1;
                n_ticks    = 16'd0;
                n_idx      = 3'd0;
                n_crc      = CRC_INIT;
                has_result = 1'b1;
                job.addr   = r_in.slave_address;
            end
            OP_RX_BYTE: begin
                if (hit_addr) begin
                    n_crc = crc_rx;
                    n_idx = 3'd1;
                end else if (r_phase == PH_COLLECT) begin
                    // store the bytes read later
                    case (r_idx)
                        3'd3:    n_rep3 = r_in.rx_byte;
                        3'd4:    n_rep4 = r_in.rx_byte;
                        3'd5:    n_rep5 = r_in.rx_byte;
                        default: ;
                    endcase
                    if (r_idx < 3'd5) begin
                        n_crc = crc_rx;
                    end
                    n_idx = r_idx + 3'd1;
                    if (frame_end) begin
                        n_idx = 3'd0;
                        n_crc = CRC_INIT;
                        if (crc_ok) begin
                            has_result  = 1'b1;
                            job.frame   = 1'b0;
                            job.reading = {r_rep3, r_rep4};
                        end
                    end
                end
            end
            OP_TICK: begin
                if (r_phase != PH_IDLE) begin
                    n_ticks = tick_nx;
                    if (expire) begin
                        n_idx      = 3'd0;
                        n_crc      = CRC_INIT;
                        n_ticks    = 16'd0;
                        has_result = 1'b1;
                        if (retry) begin
                            n_attempts = r_attempts + 2'd1;
                        end else begin
                            job.frame  = 1'b0;
                            job.status = ST_FAIL;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // commit state as a request leaves decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_target   <= 8'h00;
            r_attempts <= 2'd0;
            r_ticks    <= 16'd0;
            r_idx      <= 3'd0;
            r_crc      <= CRC_INIT;
        end else if (advance) begin
            r_phase    <= n_phase;
            r_target   <= n_target;
            r_attempts <= n_attempts;
            r_ticks    <= n_ticks;
            r_idx      <= n_idx;
            r_crc      <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_rep3 <= n_rep3;
            r_rep4 <= n_rep4;
            r_rep5 <= n_rep5;
        end
    end

    mbrtu_tx u_tx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance && has_result),
        .i_job   (job),
        .o_ready (tx_ready),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

endmodule

/* rtl/mbrtu_chk.sv */
// ----------------------------------------------------------------------------
// mbrtu_chk
// Port-level checks on the read master's result stream.
// ----------------------------------------------------------------------------
module mbrtu_chk
    import mbrtu_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic o_valid,
    input logic i_stall,
    input t_res o_res
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_res))
        else $error("stalled result changed");

    // a completion ends its request
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_res.kind == KIND_DONE) |-> o_res.last)
        else $error("completion without last");

    // frame bytes carry no status or reading
    a_tx_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_res.kind == KIND_TX) |-> (o_res.status == ST_OK) &&
        (o_res.reading == 16'h0000))
        else $error("frame byte with status or reading");

    // frame bytes follow one another without a gap
    a_tx_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_res.kind == KIND_TX) && !o_res.last
        |=> o_valid && (o_res.kind == KIND_TX))
        else $error("frame broken before its last byte");

endmodule

bind modbus_rtu_register_read_master_core mbrtu_chk u_chk (.*);
